### rtl/wav_riff_header_parser_assert.svh
// Assertion macros for the parser checker.
`ifndef WAV_RIFF_HEADER_PARSER_ASSERT_SVH
`define WAV_RIFF_HEADER_PARSER_ASSERT_SVH

// same-cycle implication
`define WRHP_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WRHP_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/wrhp_pkg.sv
`timescale 1ns / 1ps

package wrhp_pkg;

	localparam int unsigned PHASE_W = 3;
	localparam logic [PHASE_W-1:0] PH_HEAD  = 3'd0;
	localparam logic [PHASE_W-1:0] PH_FSIZE = 3'd1;
	localparam logic [PHASE_W-1:0] PH_FBODY = 3'd2;
	localparam logic [PHASE_W-1:0] PH_CID   = 3'd3;
	localparam logic [PHASE_W-1:0] PH_CSIZE = 3'd4;
	localparam logic [PHASE_W-1:0] PH_SKIP  = 3'd5;
	localparam logic [PHASE_W-1:0] PH_DATA  = 3'd6;
	localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd7;

	localparam int unsigned KIND_W = 3;
	localparam logic [KIND_W-1:0] KIND_FORMAT   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_CHANNELS = 3'd2;
	localparam logic [KIND_W-1:0] KIND_NO_DATA  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_FMT_SHORT = 3'd4;
	localparam logic [KIND_W-1:0] KIND_TRUNC    = 3'd5;

	localparam logic [31:0] ID_DATA      = {8'h64, 8'h61, 8'h74, 8'h61};
	localparam logic [15:0] MAX_CHANNELS = 16'd2;
	localparam logic [31:0] FMT_MIN_SIZE = 32'd16;
	localparam logic [3:0]  HEAD_LAST    = 4'd15;

	localparam int unsigned OUT_DATA_W = 96;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [15:0]       channel_count;
		logic              is_stereo;
		logic [31:0]       sample_rate;
		logic [31:0]       data_size;
		logic [7:0]        data_byte;
		logic              last;
	} res_t;

endpackage

### rtl/wrhp_in_stage.sv
`timescale 1ns / 1ps

module wrhp_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_valid,
	output logic       s_ready,
	input  logic [7:0] s_byte,
	input  logic       s_last,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1,
	output logic       last_s1
);

	assign s_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_ready) begin
			valid_s1 <= s_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_valid && s_ready) begin
			byte_s1 <= s_byte;
			last_s1 <= s_last;
		end
	end

endmodule

### rtl/wrhp_parse.sv
`timescale 1ns / 1ps

module wrhp_parse (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic [7:0]      in_byte,
	input  logic            fin,
	output logic            has_res,
	output wrhp_pkg::res_t  res
);

	logic [wrhp_pkg::PHASE_W-1:0] phase_q, phase_n;
	logic [31:0] cnt_q, cnt_n;
	logic [31:0] id_q, id_n;
	logic [31:0] acc_q, acc_n;
	logic [31:0] fmt_last_q, fmt_last_n;
	logic [15:0] chan_q, chan_n;
	logic [31:0] rate_q, rate_n;
	logic [31:0] rem_q, rem_n;
	logic [31:0] acc_shift;
	logic [31:0] cnt_inc;
	logic        word_done;

	assign acc_shift = {in_byte, acc_q[31:8]};
	assign cnt_inc   = cnt_q + 32'd1;
	assign word_done = (cnt_q[1:0] == 2'd3);

	always_comb begin
		phase_n    = phase_q;
		cnt_n      = cnt_q;
		id_n       = id_q;
		acc_n      = acc_q;
		fmt_last_n = fmt_last_q;
		chan_n     = chan_q;
		rate_n     = rate_q;
		rem_n      = rem_q;
		has_res    = 1'b0;
		res        = '0;
		unique case (phase_q)
			wrhp_pkg::PH_HEAD: begin
				if (cnt_q[3:0] == wrhp_pkg::HEAD_LAST) begin
					phase_n = wrhp_pkg::PH_FSIZE;
					cnt_n   = '0;
					acc_n   = '0;
				end else begin
					cnt_n = cnt_inc;
				end
			end
			wrhp_pkg::PH_FSIZE: begin
				acc_n = acc_shift;
				if (word_done) begin
					cnt_n      = '0;
					fmt_last_n = acc_shift - 32'd1;
					if (acc_shift < wrhp_pkg::FMT_MIN_SIZE) begin
						has_res  = 1'b1;
						res.kind = wrhp_pkg::KIND_FMT_SHORT;
						phase_n  = wrhp_pkg::PH_IDLE;
					end else begin
						phase_n = wrhp_pkg::PH_FBODY;
					end
				end else begin
					cnt_n = cnt_inc;
				end
			end
			wrhp_pkg::PH_FBODY: begin
				if (cnt_q[31:3] == '0) begin
					case (cnt_q[2:0])
						3'd2: chan_n[7:0]  = in_byte;
						3'd3: chan_n[15:8] = in_byte;
						3'd4: rate_n[7:0]  = in_byte;
						3'd5: rate_n[15:8] = in_byte;
						3'd6: rate_n[23:16] = in_byte;
						3'd7: rate_n[31:24] = in_byte;
						default: ;
					endcase
				end
				if (cnt_q == fmt_last_q) begin
					phase_n = wrhp_pkg::PH_CID;
					cnt_n   = '0;
					id_n    = '0;
				end else begin
					cnt_n = cnt_inc;
				end
			end
			wrhp_pkg::PH_CID: begin
				id_n = {id_q[23:0], in_byte};
				if (word_done) begin
					phase_n = wrhp_pkg::PH_CSIZE;
					cnt_n   = '0;
					acc_n   = '0;
				end else begin
					cnt_n = cnt_inc;
				end
			end
			wrhp_pkg::PH_CSIZE: begin
				acc_n = acc_shift;
				if (word_done) begin
					rem_n = acc_shift;
					cnt_n = '0;
					if (id_q == wrhp_pkg::ID_DATA) begin
						has_res           = 1'b1;
						res.channel_count = chan_q;
						res.is_stereo     = (chan_q > 16'd1);
						res.sample_rate   = rate_q;
						res.data_size     = acc_shift;
						if (chan_q > wrhp_pkg::MAX_CHANNELS) begin
							res.kind = wrhp_pkg::KIND_CHANNELS;
							phase_n  = wrhp_pkg::PH_IDLE;
						end else begin
							res.kind = wrhp_pkg::KIND_FORMAT;
							phase_n  = (acc_shift != '0) ? wrhp_pkg::PH_DATA : wrhp_pkg::PH_IDLE;
						end
					end else begin
						id_n    = '0;
						phase_n = (acc_shift != '0) ? wrhp_pkg::PH_SKIP : wrhp_pkg::PH_CID;
					end
				end else begin
					cnt_n = cnt_inc;
				end
			end
			wrhp_pkg::PH_SKIP: begin
				rem_n = rem_q - 32'd1;
				if (rem_q == 32'd1) begin
					phase_n = wrhp_pkg::PH_CID;
					cnt_n   = '0;
					id_n    = '0;
				end
			end
			wrhp_pkg::PH_DATA: begin
				has_res       = 1'b1;
				res.kind      = wrhp_pkg::KIND_PAYLOAD;
				res.data_byte = in_byte;
				res.last      = (rem_q == 32'd1);
				rem_n         = rem_q - 32'd1;
				if (rem_q == 32'd1) begin
					phase_n = wrhp_pkg::PH_IDLE;
				end
			end
			default: ;
		endcase

		if (fin) begin
			if (phase_n == wrhp_pkg::PH_DATA) begin
				has_res  = 1'b1;
				res      = '0;
				res.kind = wrhp_pkg::KIND_TRUNC;
			end else if (phase_n != wrhp_pkg::PH_IDLE && !has_res) begin
				has_res  = 1'b1;
				res.kind = wrhp_pkg::KIND_NO_DATA;
			end
			phase_n    = wrhp_pkg::PH_HEAD;
			cnt_n      = '0;
			id_n       = '0;
			acc_n      = '0;
			fmt_last_n = '0;
			chan_n     = '0;
			rate_n     = '0;
			rem_n      = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= wrhp_pkg::PH_HEAD;
			cnt_q      <= '0;
			id_q       <= '0;
			acc_q      <= '0;
			fmt_last_q <= '0;
			chan_q     <= '0;
			rate_q     <= '0;
			rem_q      <= '0;
		end else if (step) begin
			phase_q    <= phase_n;
			cnt_q      <= cnt_n;
			id_q       <= id_n;
			acc_q      <= acc_n;
			fmt_last_q <= fmt_last_n;
			chan_q     <= chan_n;
			rate_q     <= rate_n;
			rem_q      <= rem_n;
		end
	end

endmodule

### rtl/wrhp_out_stage.sv
`timescale 1ns / 1ps

module wrhp_out_stage (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  load,
	input  wrhp_pkg::res_t                        res,
	output logic                                  free,
	output logic                                  m_valid,
	input  logic                                  m_ready,
	output logic [wrhp_pkg::OUT_DATA_W-1:0]       m_data,
	output logic [wrhp_pkg::KIND_W-1:0]           m_user,
	output logic                                  m_last
);

	wrhp_pkg::res_t res_q;
	logic           valid_q;

	assign free    = !valid_q || m_ready;
	assign m_valid = valid_q;
	assign m_user  = res_q.kind;
	assign m_last  = res_q.last;
	assign m_data  = {7'd0, res_q.data_byte, res_q.data_size, res_q.sample_rate,
		res_q.is_stereo, res_q.channel_count};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			res_q <= res;
		end
	end

endmodule

### rtl/wav_riff_header_parser.sv
`timescale 1ns / 1ps
// WAVE header parser. Feed the file image as one byte per request on the
// s_axis channel; s_axis_tlast marks the final byte of a buffer, after which
// the parser starts over on a fresh image.
// Results leave on m_axis: tuser holds the kind (format, payload byte or one
// of the error codes), tlast marks the final payload byte, tdata holds the
// format fields and the payload byte.
// Bytes that yield no result are consumed without touching m_axis.
// A result is presented on m_axis after its byte passes the input register,
// then the result register.
// Throughput: one byte per cycle while no result-bearing byte waits on a
// stalled receiver; the state update sits between the two registers.
// Reset (arst_n low) empties both registers and returns the parser to the
// start of the header.
// When the receiver stalls, the result register holds its request; bytes
// that give no result keep flowing, and the first byte that does give one
// waits in the input register, which then drops s_axis_tready.

module wav_riff_header_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [15:0] channel_count, [16] is_stereo, [48:17] sample_rate,
	// [80:49] data_size, [88:81] data_byte, [95:89] zero
	output logic [95:0] m_axis_tdata,
	output logic [2:0]  m_axis_tuser,   // [2:0] kind
	output logic        m_axis_tlast
);

	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           last_s1;
	logic           advance;
	logic           has_res;
	logic           out_free;
	wrhp_pkg::res_t res;

	assign advance = valid_s1 && (!has_res || out_free);

	wrhp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_valid  (s_axis_tvalid),
		.s_ready  (s_axis_tready),
		.s_byte   (s_axis_tdata),
		.s_last   (s_axis_tlast),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.last_s1  (last_s1)
	);

	wrhp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.in_byte (byte_s1),
		.fin     (last_s1),
		.has_res (has_res),
		.res     (res)
	);

	wrhp_out_stage u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (advance && has_res),
		.res     (res),
		.free    (out_free),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.m_data  (m_axis_tdata),
		.m_user  (m_axis_tuser),
		.m_last  (m_axis_tlast)
	);

endmodule

### rtl/wrhp_checker.sv
`timescale 1ns / 1ps
`include "wav_riff_header_parser_assert.svh"

module wrhp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [95:0] m_axis_tdata,
	input logic [2:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	`WRHP_ASSERT_NEXT(a_hold_stalled, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled request changed")
	`WRHP_ASSERT_IMPL(a_kind_range, m_axis_tvalid, m_axis_tuser <= wrhp_pkg::KIND_TRUNC, "kind out of range")
	`WRHP_ASSERT_IMPL(a_last_payload, m_axis_tvalid && m_axis_tlast, m_axis_tuser == wrhp_pkg::KIND_PAYLOAD, "tlast on non-payload request")
	`WRHP_ASSERT_IMPL(a_stereo_flag, m_axis_tvalid && (m_axis_tuser == wrhp_pkg::KIND_FORMAT || m_axis_tuser == wrhp_pkg::KIND_CHANNELS), m_axis_tdata[16] == (m_axis_tdata[15:0] > 16'd1), "stereo flag disagrees with channel count")

endmodule

bind wav_riff_header_parser wrhp_checker u_wrhp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
